// File: rtl/stock_span_monotonic_stack_core_macros.svh
// Assertion macros shared by the stock span modules.
`ifndef STOCK_SPAN_MONOTONIC_STACK_CORE_MACROS_SVH
`define STOCK_SPAN_MONOTONIC_STACK_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stock span: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SSMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stock span: next-cycle check failed");

`endif

// File: rtl/ssms_pkg.sv
// Constants and types shared by the stock span modules.
package ssms_pkg;

	localparam int MAX_ITEMS   = 1024;
	localparam int PRICE_BITS  = 16;
	localparam int IDX_BITS    = $clog2(MAX_ITEMS);
	localparam int CNT_BITS    = $clog2(MAX_ITEMS + 1);
	localparam int SPAN_BITS   = 11;
	localparam int ENTRY_BITS  = PRICE_BITS + IDX_BITS;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// One classified item as it travels from the front end to the stack engine.
	typedef struct packed {
		logic [PRICE_BITS-1:0] price;
		logic                  start;
		logic                  ovf;
		logic [IDX_BITS-1:0]   idx;
	} item_t;

endpackage

// File: rtl/ssms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ssms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/ssms_front.sv
// Front end: accepts beats, tracks the series position and queues tagged items.
`include "stock_span_monotonic_stack_core_macros.svh"

module ssms_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [15:0]                     price,
	input  logic                            series_start,
	input  logic                            in_valid,
	output logic                            in_ready,
	output logic                            q_valid,
	input  logic                            q_ready,
	output ssms_pkg::item_t                 q_item
);

	logic [ssms_pkg::CNT_BITS-1:0]  count_q;
	logic [ssms_pkg::CNT_BITS-1:0]  pos;
	logic                           is_ovf;
	logic                           push;
	logic                           pop;
	ssms_pkg::item_t                new_item;
	ssms_pkg::item_t                slot_q [ssms_pkg::QUEUE_DEPTH];
	logic [ssms_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [ssms_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [ssms_pkg::QCNT_BITS-1:0] used_q;

	assign in_ready = (used_q != ssms_pkg::QCNT_BITS'(ssms_pkg::QUEUE_DEPTH));
	assign q_valid  = (used_q != '0);
	assign q_item   = slot_q[rd_ptr_q];
	assign push     = in_valid & in_ready;
	assign pop      = q_valid & q_ready;

	// A series start makes this item element 0 whatever came before.
	assign pos    = series_start ? '0 : count_q;
	assign is_ovf = (pos == ssms_pkg::CNT_BITS'(ssms_pkg::MAX_ITEMS));

	always_comb begin
		new_item.price = price[ssms_pkg::PRICE_BITS-1:0];
		new_item.start = series_start;
		new_item.ovf   = is_ovf;
		new_item.idx   = pos[ssms_pkg::IDX_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (push) begin
				// The position saturates once the series is too long.
				count_q  <= is_ovf ? pos : pos + 1'b1;
				wr_ptr_q <= (wr_ptr_q == ssms_pkg::QPTR_BITS'(ssms_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ssms_pkg::QPTR_BITS'(ssms_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				used_q <= used_q + 1'b1;
			end else if (pop && !push) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	`SSMS_ASSERT_IMP(a_queue_bound, clk, arst_n, 1'b1, used_q <= ssms_pkg::QUEUE_DEPTH)
	`SSMS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= ssms_pkg::MAX_ITEMS)
	`SSMS_ASSERT_NEXT(a_count_step, clk, arst_n, push && !series_start && !is_ovf, count_q == $past(count_q) + 1'b1)

endmodule

// File: rtl/ssms_back.sv
// Stack engine: pops lower or equal prices, computes the span and pushes each item that is not an overflow.
`include "stock_span_monotonic_stack_core_macros.svh"

module ssms_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_ready,
	input  ssms_pkg::item_t                q_item,
	output logic [ssms_pkg::SPAN_BITS-1:0] span,
	output logic                           overflow,
	output logic                           out_valid,
	input  logic                           out_ready
);

	typedef enum logic {
		ST_IDLE,
		ST_CMP
	} state_t;

	state_t                             state_q;
	ssms_pkg::item_t                    item_q;
	logic [ssms_pkg::CNT_BITS-1:0]      fill_q;
	logic [ssms_pkg::PRICE_BITS-1:0]    top_price_q;
	logic [ssms_pkg::IDX_BITS-1:0]      top_idx_q;
	logic                               from_ram_q;
	logic [ssms_pkg::SPAN_BITS-1:0]     span_q;
	logic                               ovf_q;
	logic                               out_valid_q;

	logic [ssms_pkg::PRICE_BITS-1:0]    cur_price;
	logic [ssms_pkg::IDX_BITS-1:0]      cur_idx;
	logic [ssms_pkg::CNT_BITS-1:0]      fill_dec;
	logic [ssms_pkg::CNT_BITS-1:0]      fill_m2;
	logic [ssms_pkg::SPAN_BITS-1:0]     span_calc;
	logic                               out_free;
	logic                               do_pop;
	logic                               do_push;
	logic                               do_ovf;
	logic                               ram_re;
	logic [ssms_pkg::ENTRY_BITS-1:0]    ram_rdata;

	ssms_ram #(
		.WIDTH(ssms_pkg::ENTRY_BITS),
		.DEPTH(ssms_pkg::MAX_ITEMS)
	) u_stack (
		.clk   (clk),
		.we    (do_push),
		.waddr (fill_q[ssms_pkg::IDX_BITS-1:0]),
		.wdata ({item_q.price, item_q.idx}),
		.re    (ram_re),
		.raddr (fill_m2[ssms_pkg::IDX_BITS-1:0]),
		.rdata (ram_rdata)
	);

	// The top entry is cached; after a pop the new top arrives from the registered RAM read.
	assign cur_price = from_ram_q ? ram_rdata[ssms_pkg::ENTRY_BITS-1:ssms_pkg::IDX_BITS] :
		top_price_q;
	assign cur_idx   = from_ram_q ? ram_rdata[ssms_pkg::IDX_BITS-1:0] : top_idx_q;

	assign fill_dec  = fill_q - 1'b1;
	assign fill_m2   = fill_q - ssms_pkg::CNT_BITS'(2);
	assign out_free  = !out_valid_q || out_ready;
	assign q_ready   = (state_q == ST_IDLE);

	assign do_pop  = (state_q == ST_CMP) && !item_q.ovf && (fill_q != '0) &&
		(item_q.price >= cur_price);
	assign do_push = (state_q == ST_CMP) && !item_q.ovf && !do_pop && out_free;
	assign do_ovf  = (state_q == ST_CMP) && item_q.ovf && out_free;
	assign ram_re  = do_pop && (fill_dec != '0);

	assign span_calc = (fill_q == '0) ?
		ssms_pkg::SPAN_BITS'(item_q.idx) + 1'b1 :
		ssms_pkg::SPAN_BITS'(item_q.idx) - ssms_pkg::SPAN_BITS'(cur_idx);

	assign span      = span_q;
	assign overflow  = ovf_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			fill_q      <= '0;
			top_price_q <= '0;
			top_idx_q   <= '0;
			from_ram_q  <= 1'b0;
			span_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one taken in the same cycle.
			if (do_push || do_ovf) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						if (q_item.start) begin
							fill_q <= '0;
						end
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					from_ram_q <= ram_re;
					if (do_push) begin
						top_price_q <= item_q.price;
						top_idx_q   <= item_q.idx;
					end else if (from_ram_q) begin
						top_price_q <= cur_price;
						top_idx_q   <= cur_idx;
					end
					if (do_pop) begin
						fill_q <= fill_dec;
					end else if (do_ovf) begin
						span_q  <= '0;
						ovf_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else if (do_push) begin
						fill_q  <= fill_q + 1'b1;
						span_q  <= span_calc;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SSMS_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= ssms_pkg::MAX_ITEMS)
	`SSMS_ASSERT_IMP(a_idle_no_read, clk, arst_n, state_q == ST_IDLE, !from_ram_q)
	`SSMS_ASSERT_NEXT(a_pop_refill, clk, arst_n, ram_re, from_ram_q && state_q == ST_CMP)
	`SSMS_ASSERT_IMP(a_ovf_span, clk, arst_n, out_valid_q && ovf_q, span_q == '0)

endmodule

// File: rtl/stock_span_monotonic_stack_core.sv
// Top level of the stock span engine: front end, item queue and stack engine.
//
//   Channel  Direction  Handshake              Beat contents
//   input    in         in_valid / in_ready    price, series_start
//   output   out        out_valid / out_ready  span, overflow
//
// Each item passes through the idle and compare states of the stack engine, and the
// compare state pops stack entries one at a time, reading each successor from the stack RAM.
// A two-entry queue lets the front end keep taking beats while the engine works,
// and the output register lets the engine work through the next item's pops while a result waits.
// Reset is asynchronous and needs no clearing pass: only live entries are read.
// A stalled output holds the engine on its current item until the beat is taken.
module stock_span_monotonic_stack_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] price,
	input  logic        series_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] span,
	output logic        overflow
);

	logic            q_valid;
	logic            q_ready;
	ssms_pkg::item_t q_item;

	ssms_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.price        (price),
		.series_start (series_start),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item)
	);

	ssms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.span      (span),
		.overflow  (overflow),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule
